>>> sv/hrhc_pkg.sv
// shared types, constants and character helpers for the http request head checker
`default_nettype none
package hrhc_pkg;

    localparam int LINE_MAX_DEF = 1000;

    typedef enum logic [1:0] {
        PH_REQ  = 2'd0,
        PH_HDR  = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SH_EMPTY = 2'd0,
        SH_CR    = 2'd1,
        SH_OTHER = 2'd2
    } shape_t;

    localparam logic [1:0] V_OK  = 2'd0;
    localparam logic [1:0] V_400 = 2'd1;
    localparam logic [1:0] V_501 = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [23:0] DOTS_TAIL = 24'h2F2E2E;

    localparam logic [2:0] MP_DONE = 3'd3;
    localparam logic [2:0] MP_BAD  = 3'd4;
    localparam logic [3:0] VP_DONE = 4'd8;
    localparam logic [3:0] VP_BAD  = 4'd15;
    localparam logic [2:0] TC_MAX  = 3'd4;

    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h47;
            2'd1:    c = 8'h45;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ver_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            3'd5:    c = 8'h31;
            3'd6:    c = 8'h2E;
            default: c = 8'h30;
        endcase
        return c;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_TAB) || (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage
`default_nettype wire

>>> sv/http_request_head_checker.sv
// http request head checker: one byte per beat, one verdict per connection
// path: an accepted beat passes the input register, its verdict the result register;
// throughput: one byte per cycle unless the master side stalls, set by the state
// update between the two registers; a stalled master side holds one verdict
// reset: rst_n asynchronous active low clears all parser state and both stage valids
// a beat with s_tlast high ends the connection and returns the parser to reset state
`default_nettype none
module http_request_head_checker
    import hrhc_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // data_byte[7:0]
    input  wire logic       s_tlast,   // closed
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // verdict[1:0], reply_sent[2], zero[7:3]
);

    localparam int LCW = $clog2(LINE_MAX);
    localparam logic [LCW-1:0] LC_FULL = LCW'(LINE_MAX - 1);

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_closed_reg;

    // parser state
    phase_t         phase_reg, phase_next;
    logic [LCW-1:0] line_count_reg, line_count_next;
    logic [2:0]     token_count_reg, token_count_next;
    logic           inside_token_reg, inside_token_next;
    logic           zero_end_reg, zero_end_next;
    logic [2:0]     method_prog_reg, method_prog_next;
    logic [3:0]     version_prog_reg, version_prog_next;
    logic           uri_bad_start_reg, uri_bad_start_next;
    logic [23:0]    uri_tail_reg, uri_tail_next;
    logic           traversal_reg, traversal_next;
    shape_t         shape_reg, shape_next;

    // result register
    logic       out_vld_reg;
    logic [1:0] out_verdict_reg;
    logic       out_reply_reg;

    logic       proc_go;
    logic       res_vld;
    logic [1:0] res_verdict;
    logic       res_reply;

    assign proc_go  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || proc_go;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_reply_reg, out_verdict_reg};

    function automatic logic [1:0] judge(
        input logic [2:0]  tc,
        input logic [2:0]  mp,
        input logic [3:0]  vp,
        input logic        bad_start,
        input logic        trav,
        input logic [23:0] tail
    );
        logic [1:0] v;
        priority if (tc != 3'd3)                  v = V_501;
        else if (mp != MP_DONE)                   v = V_501;
        else if (vp != VP_DONE)                   v = V_501;
        else if (bad_start)                       v = V_400;
        else if (trav || (tail == DOTS_TAIL))     v = V_400;
        else                                      v = V_OK;
        return v;
    endfunction

    always_comb
    begin
        logic [7:0]     c;
        logic [LCW-1:0] lc_inc;
        logic           nl;
        logic           full;
        logic [1:0]     v;

        c      = in_byte_reg;
        lc_inc = line_count_reg + LCW'(1);
        nl     = (c == CH_LF);
        full   = (lc_inc >= LC_FULL);
        v      = V_OK;

        phase_next         = phase_reg;
        line_count_next    = line_count_reg;
        token_count_next   = token_count_reg;
        inside_token_next  = inside_token_reg;
        zero_end_next      = zero_end_reg;
        method_prog_next   = method_prog_reg;
        version_prog_next  = version_prog_reg;
        uri_bad_start_next = uri_bad_start_reg;
        uri_tail_next      = uri_tail_reg;
        traversal_next     = traversal_reg;
        shape_next         = shape_reg;

        res_vld     = 1'b0;
        res_verdict = V_400;
        res_reply   = 1'b0;

        if (in_closed_reg)
        begin
            if (phase_reg == PH_REQ)
            begin
                res_vld = 1'b1;
                if (line_count_reg != '0)
                    v = judge(token_count_reg, method_prog_reg, version_prog_reg,
                              uri_bad_start_reg, traversal_reg, uri_tail_reg);
                if (v != V_OK)
                begin
                    res_verdict = v;
                    res_reply   = 1'b1;
                end
            end
            else if (phase_reg == PH_HDR)
            begin
                res_vld = 1'b1;
            end
            phase_next         = PH_REQ;
            line_count_next    = '0;
            token_count_next   = '0;
            inside_token_next  = 1'b0;
            zero_end_next      = 1'b0;
            method_prog_next   = '0;
            version_prog_next  = '0;
            uri_bad_start_next = 1'b0;
            uri_tail_next      = '0;
            traversal_next     = 1'b0;
            shape_next         = SH_EMPTY;
        end
        else if (phase_reg == PH_REQ)
        begin
            line_count_next = lc_inc;
            // token scan, stops for good at a zero byte
            if (!zero_end_reg)
            begin
                if (c == CH_NUL)
                begin
                    zero_end_next     = 1'b1;
                    inside_token_next = 1'b0;
                end
                else if (is_sep(c))
                begin
                    inside_token_next = 1'b0;
                end
                else
                begin
                    if (!inside_token_reg)
                    begin
                        inside_token_next = 1'b1;
                        if (token_count_reg < TC_MAX)
                            token_count_next = token_count_reg + 3'd1;
                        if (token_count_next == 3'd2)
                            uri_bad_start_next = (c != CH_SLASH);
                    end
                    if (token_count_next == 3'd1)
                    begin
                        if (method_prog_reg < MP_DONE && c == get_char(method_prog_reg[1:0]))
                            method_prog_next = method_prog_reg + 3'd1;
                        else
                            method_prog_next = MP_BAD;
                    end
                    else if (token_count_next == 3'd2)
                    begin
                        if (uri_tail_reg == DOTS_TAIL && c == CH_SLASH)
                            traversal_next = 1'b1;
                        uri_tail_next = {uri_tail_reg[15:0], c};
                    end
                    else if (token_count_next == 3'd3)
                    begin
                        if (version_prog_reg < VP_DONE &&
                            (c == ver_char(version_prog_reg[2:0]) ||
                             (version_prog_reg == 4'd7 && c == CH_ONE)))
                            version_prog_next = version_prog_reg + 4'd1;
                        else
                            version_prog_next = VP_BAD;
                    end
                end
            end
            if (nl || full)
            begin
                v = judge(token_count_next, method_prog_next, version_prog_next,
                          uri_bad_start_next, traversal_next, uri_tail_next);
                if (v != V_OK)
                begin
                    phase_next  = PH_DONE;
                    res_vld     = 1'b1;
                    res_verdict = v;
                    res_reply   = 1'b1;
                end
                else
                begin
                    phase_next      = PH_HDR;
                    line_count_next = '0;
                    shape_next      = SH_EMPTY;
                end
            end
        end
        else if (phase_reg == PH_HDR)
        begin
            line_count_next = lc_inc;
            if (nl)
            begin
                if (shape_reg == SH_EMPTY || shape_reg == SH_CR)
                begin
                    phase_next  = PH_DONE;
                    res_vld     = 1'b1;
                    res_verdict = V_OK;
                    res_reply   = 1'b1;
                end
                else
                begin
                    line_count_next = '0;
                    shape_next      = SH_EMPTY;
                end
            end
            else
            begin
                if (c == CH_CR && shape_reg == SH_EMPTY)
                    shape_next = SH_CR;
                else
                    shape_next = SH_OTHER;
                if (full)
                begin
                    line_count_next = '0;
                    shape_next      = SH_EMPTY;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg   <= s_tdata;
            in_closed_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_REQ;
            line_count_reg    <= '0;
            token_count_reg   <= '0;
            inside_token_reg  <= 1'b0;
            zero_end_reg      <= 1'b0;
            method_prog_reg   <= '0;
            version_prog_reg  <= '0;
            uri_bad_start_reg <= 1'b0;
            uri_tail_reg      <= '0;
            traversal_reg     <= 1'b0;
            shape_reg         <= SH_EMPTY;
        end
        else if (proc_go)
        begin
            phase_reg         <= phase_next;
            line_count_reg    <= line_count_next;
            token_count_reg   <= token_count_next;
            inside_token_reg  <= inside_token_next;
            zero_end_reg      <= zero_end_next;
            method_prog_reg   <= method_prog_next;
            version_prog_reg  <= version_prog_next;
            uri_bad_start_reg <= uri_bad_start_next;
            uri_tail_reg      <= uri_tail_next;
            traversal_reg     <= traversal_next;
            shape_reg         <= shape_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (proc_go && res_vld)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && res_vld)
        begin
            out_verdict_reg <= res_verdict;
            out_reply_reg   <= res_reply;
        end
    end

endmodule
`default_nettype wire
